// ----- sv/bcdc_pkg.sv -----
// Shared types, constants and digit helpers for the BCD clock with alarm.
`timescale 1ns / 1ps

package bcdc_pkg;

    typedef enum logic [1:0] {
        CMD_TICK      = 2'd0,
        CMD_SET_TIME  = 2'd1,
        CMD_SET_ALARM = 2'd2,
        CMD_POSTPONE  = 2'd3
    } bcdc_cmd_t;

    // Register word index, taken from paddr[2]
    localparam logic REG_TICK_DIV = 1'b0;
    localparam logic REG_ALARM_EN = 1'b1;

    localparam logic [15:0] TICK_DIV_RESET = 16'd1000;

    // floor(x / 60) = (x * RECIP60) >> RECIP60_SHIFT, exact for 16-bit x
    localparam logic [16:0] RECIP60       = 17'd69906;
    localparam int          RECIP60_SHIFT = 22;
    // floor(q / 24) = (q * RECIP24) >> RECIP24_SHIFT, exact for 11-bit q
    localparam logic [11:0] RECIP24       = 12'd2731;
    localparam int          RECIP24_SHIFT = 16;

    typedef struct packed {
        bcdc_cmd_t   cmd;
        logic [23:0] time_bcd;
        logic [15:0] snooze_min;
    } bcdc_req_t;

    typedef struct packed {
        logic [23:0] now_bcd;
        logic [23:0] alarm_bcd;
        logic        time_valid;
        logic        set_ok;
        logic        alarm_fired;
    } bcdc_res_t;

    // Request after the minute split: hour 0..23 and minute 0..59 of the
    // operand (delay for postpone, weighted alarm digits for set alarm).
    typedef struct packed {
        bcdc_cmd_t   cmd;
        logic [23:0] time_bcd;
        logic [4:0]  hh;
        logic [5:0]  mm;
    } bcdc_item_t;

    // Raw nibbles weighted as minutes: tens*600 + units*60 + tens*10 + units
    function automatic logic [13:0] hhmm_weight(input logic [23:0] t);
        logic [13:0] w;
        w = {10'd0, t[23:20]} * 14'd600
          + {10'd0, t[19:16]} * 14'd60
          + {10'd0, t[15:12]} * 14'd10
          + {10'd0, t[11:8]};
        return w;
    endfunction

    // Two BCD digits of a value 0..59
    function automatic logic [7:0] to_bcd2(input logic [5:0] v);
        logic [3:0] tens;
        logic [5:0] units;
        if (v >= 6'd50)
            tens = 4'd5;
        else if (v >= 6'd40)
            tens = 4'd4;
        else if (v >= 6'd30)
            tens = 4'd3;
        else if (v >= 6'd20)
            tens = 4'd2;
        else if (v >= 6'd10)
            tens = 4'd1;
        else
            tens = 4'd0;
        units = v - {2'd0, tens} * 6'd10;
        return {tens, units[3:0]};
    endfunction

    function automatic logic time_ok(input logic [23:0] t);
        logic ok;
        ok = 1'b1;
        if (t[23:20] > 4'd2)
            ok = 1'b0;
        if (t[23:20] == 4'd2 && t[19:16] > 4'd3)
            ok = 1'b0;
        if (t[19:16] > 4'd9)
            ok = 1'b0;
        if (t[15:12] > 4'd5)
            ok = 1'b0;
        if (t[11:8] > 4'd9)
            ok = 1'b0;
        if (t[7:4] > 4'd5)
            ok = 1'b0;
        if (t[3:0] > 4'd9)
            ok = 1'b0;
        return ok;
    endfunction

    // One second forward with digit carries; 23:59:59 wraps to 00:00:00
    function automatic logic [23:0] advance_second(input logic [23:0] t);
        logic [4:0] d0, d1, d2, d3, d4, d5;
        d0 = {1'b0, t[3:0]} + 5'd1;
        d1 = {1'b0, t[7:4]};
        d2 = {1'b0, t[11:8]};
        d3 = {1'b0, t[15:12]};
        d4 = {1'b0, t[19:16]};
        d5 = {1'b0, t[23:20]};
        if (d0 > 5'd9)
        begin
            d0 = 5'd0;
            d1 = d1 + 5'd1;
            if (d1 > 5'd5)
            begin
                d1 = 5'd0;
                d2 = d2 + 5'd1;
                if (d2 > 5'd9)
                begin
                    d2 = 5'd0;
                    d3 = d3 + 5'd1;
                    if (d3 > 5'd5)
                    begin
                        d3 = 5'd0;
                        d4 = d4 + 5'd1;
                        if ((d5 == 5'd2 && d4 > 5'd3) || (d5 < 5'd2 && d4 > 5'd9))
                        begin
                            d4 = 5'd0;
                            d5 = d5 + 5'd1;
                            if (d5 > 5'd2)
                                d5 = 5'd0;
                        end
                    end
                end
            end
        end
        return {d5[3:0], d4[3:0], d3[3:0], d2[3:0], d1[3:0], d0[3:0]};
    endfunction

endpackage

// ----- sv/bcd_clock_with_alarm.sv -----
// Top level: 24-hour BCD clock with alarm, snooze and register port.
// A request passes the prep registers s1..s4 and then the output register.
// Throughput: one request per cycle unless the output stalls; the clock
// and alarm state update at the output register, the minute split ahead of it is piped.
// Reset clears the time, alarm, prescaler and valid mark; divisor resets to
// 1000 and the alarm is disabled. No clearing pass is needed.
`timescale 1ns / 1ps

module bcd_clock_with_alarm
    import bcdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  bcdc_req_t   req_data,
    output logic        res_valid,
    input  logic        res_stall,
    output bcdc_res_t   res_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       item_valid;
    logic       item_ready;
    bcdc_item_t item;

    logic [15:0] tick_div_reg;
    logic        alarm_en_reg;

    logic [15:0] count_reg, count_next;
    logic [23:0] now_reg, now_next;
    logic        valid_mark_reg, valid_mark_next;
    logic [23:0] alarm_reg, alarm_next;
    logic [4:0]  alarm_hr_reg, alarm_hr_next;
    logic [5:0]  alarm_min_reg, alarm_min_next;

    logic        res_valid_reg;
    bcdc_res_t   res_reg, res_next;

    logic        fire;
    logic        set_ok;
    logic        fired;
    logic [15:0] div_eff;
    logic [16:0] count_inc;
    logic [23:0] now_adv;
    logic [6:0]  min_sum;
    logic        min_carry;
    logic [5:0]  min_new;
    logic [5:0]  hr_sum;
    logic [4:0]  hr_new;
    logic [5:0]  hr_sub;
    logic        cfg_wr;

    bcdc_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        if (paddr[2] == REG_ALARM_EN)
            prdata = {31'd0, alarm_en_reg};
        else
            prdata = {16'd0, tick_div_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_div_reg <= TICK_DIV_RESET;
            alarm_en_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_TICK_DIV)
                tick_div_reg <= pwdata[15:0];
            else
                alarm_en_reg <= pwdata[0];
        end
    end

    // Step the clock state for the request leaving the pipeline
    assign item_ready = !res_valid_reg || !res_stall;
    assign fire       = item_valid && item_ready;

    always_comb
    begin
        div_eff   = (tick_div_reg == 16'd0) ? 16'd1 : tick_div_reg;
        count_inc = {1'b0, count_reg} + 17'd1;
        now_adv   = advance_second(now_reg);

        // Postpone: add hour/minute of the delay, carry minutes, wrap hours
        min_sum   = {1'b0, alarm_min_reg} + {1'b0, item.mm};
        min_carry = (min_sum >= 7'd60);
        min_new   = min_carry ? 6'(min_sum - 7'd60) : min_sum[5:0];
        hr_sum    = {1'b0, alarm_hr_reg} + {1'b0, item.hh} + {5'd0, min_carry};
        hr_sub    = hr_sum - 6'd24;
        hr_new    = (hr_sum >= 6'd24) ? hr_sub[4:0] : hr_sum[4:0];

        count_next      = count_reg;
        now_next        = now_reg;
        valid_mark_next = valid_mark_reg;
        alarm_next      = alarm_reg;
        alarm_hr_next   = alarm_hr_reg;
        alarm_min_next  = alarm_min_reg;
        set_ok          = 1'b0;
        fired           = 1'b0;

        if (fire)
        begin
            case (item.cmd)
                CMD_TICK:
                begin
                    if (count_inc >= {1'b0, div_eff})
                    begin
                        count_next = 16'd0;
                        now_next   = now_adv;
                        fired      = alarm_en_reg && (now_adv == alarm_reg);
                    end
                    else
                    begin
                        count_next = count_inc[15:0];
                    end
                end
                CMD_SET_TIME:
                begin
                    if (time_ok(item.time_bcd))
                    begin
                        now_next        = item.time_bcd;
                        valid_mark_next = 1'b1;
                        set_ok          = 1'b1;
                    end
                end
                CMD_SET_ALARM:
                begin
                    alarm_next     = item.time_bcd;
                    alarm_hr_next  = item.hh;
                    alarm_min_next = item.mm;
                end
                CMD_POSTPONE:
                begin
                    alarm_next     = {to_bcd2({1'b0, hr_new}), to_bcd2(min_new),
                                      alarm_reg[7:0]};
                    alarm_hr_next  = hr_new;
                    alarm_min_next = min_new;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end

        res_next.now_bcd     = now_next;
        res_next.alarm_bcd   = alarm_next;
        res_next.time_valid  = valid_mark_next;
        res_next.set_ok      = set_ok;
        res_next.alarm_fired = fired;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= 16'd0;
            now_reg        <= 24'd0;
            valid_mark_reg <= 1'b0;
            alarm_reg      <= 24'd0;
            alarm_hr_reg   <= 5'd0;
            alarm_min_reg  <= 6'd0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            now_reg        <= now_next;
            valid_mark_reg <= valid_mark_next;
            alarm_reg      <= alarm_next;
            alarm_hr_reg   <= alarm_hr_next;
            alarm_min_reg  <= alarm_min_next;
            if (fire)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    // Hold the result while stalled
    always_ff @(posedge clk)
    begin
        if (fire)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

`ifndef SYNTHESIS
    a_now_valid_time: assert property (@(posedge clk) disable iff (!rst_n)
        time_ok(now_reg))
        else $error("time of day left the valid range");

    a_mark_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(valid_mark_reg))
        else $error("time valid mark dropped");

    a_fired_match: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.alarm_fired |-> res_reg.now_bcd == res_reg.alarm_bcd)
        else $error("alarm fired without a time match");

    a_set_ok_mark: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.set_ok |-> res_reg.time_valid)
        else $error("accepted set without valid mark");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(res_reg.set_ok && res_reg.alarm_fired))
        else $error("set and fire flags in one result");
`endif

endmodule

// ----- sv/bcdc_prep.sv -----
// Four-stage pipeline that splits a minute count into hour and minute mod one day.
`timescale 1ns / 1ps

module bcdc_prep
    import bcdc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  bcdc_req_t  req_data,
    output logic       item_valid,
    input  logic       item_ready,
    output bcdc_item_t item
);

    typedef struct packed {
        bcdc_cmd_t   cmd;
        logic [23:0] time_bcd;
        logic [15:0] x;
    } s1_t;

    typedef struct packed {
        bcdc_cmd_t   cmd;
        logic [23:0] time_bcd;
        logic [15:0] x;
        logic [10:0] q60;
    } s2_t;

    typedef struct packed {
        bcdc_cmd_t   cmd;
        logic [23:0] time_bcd;
        logic [10:0] q60;
        logic [5:0]  q24;
        logic [5:0]  mm;
    } s3_t;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;
    bcdc_item_t s4_reg, s4_next;

    logic rdy1, rdy2, rdy3, rdy4;

    logic [32:0] prod60;
    logic [22:0] prod24;
    logic [15:0] min_off;
    logic [15:0] min_rem;
    logic [10:0] hr_off;
    logic [10:0] hr_rem;

    assign rdy4 = !v4_reg || item_ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign req_stall  = !rdy1;
    assign item_valid = v4_reg;
    assign item       = s4_reg;

    always_comb
    begin
        s1_next.cmd      = req_data.cmd;
        s1_next.time_bcd = req_data.time_bcd;
        if (req_data.cmd == CMD_SET_ALARM)
            s1_next.x = {2'd0, hhmm_weight(req_data.time_bcd)};
        else
            s1_next.x = req_data.snooze_min;

        prod60           = {17'd0, s1_reg.x} * {16'd0, RECIP60};
        s2_next.cmd      = s1_reg.cmd;
        s2_next.time_bcd = s1_reg.time_bcd;
        s2_next.x        = s1_reg.x;
        s2_next.q60      = prod60[RECIP60_SHIFT +: 11];

        min_off          = {5'd0, s2_reg.q60} * 16'd60;
        min_rem          = s2_reg.x - min_off;
        prod24           = {12'd0, s2_reg.q60} * {11'd0, RECIP24};
        s3_next.cmd      = s2_reg.cmd;
        s3_next.time_bcd = s2_reg.time_bcd;
        s3_next.q60      = s2_reg.q60;
        s3_next.q24      = prod24[RECIP24_SHIFT +: 6];
        s3_next.mm       = min_rem[5:0];

        hr_off           = {5'd0, s3_reg.q24} * 11'd24;
        hr_rem           = s3_reg.q60 - hr_off;
        s4_next.cmd      = s3_reg.cmd;
        s4_next.time_bcd = s3_reg.time_bcd;
        s4_next.hh       = hr_rem[4:0];
        s4_next.mm       = s3_reg.mm;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= req_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && req_valid)
            s1_reg <= s1_next;
        if (rdy2 && v1_reg)
            s2_reg <= s2_next;
        if (rdy3 && v2_reg)
            s3_reg <= s3_next;
        if (rdy4 && v3_reg)
            s4_reg <= s4_next;
    end

endmodule
